### design/wcf_pkg.sv
// shared types and constants of the window convolution filter
// no dependencies; imported by every other file of the block except wcf_ram
package wcf_pkg;

    localparam int PIX_W      = 8;
    localparam int CIDX_W     = 5;
    localparam int COEF_W     = 18;
    localparam int RAD_W      = 2;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 12;
    localparam int ROW_W      = 12;
    localparam int DIM_W      = 13;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_COEF  = 1'b1
    } func_t;

    typedef struct packed {
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] y;
    } wcf_meta_t;

endpackage

### design/wcf_ifs.sv
// stream interfaces for pixel/coefficient items and filtered results
// depends on wcf_pkg
interface wcf_in_if;
    import wcf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [PIX_W-1:0]         pixel;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;

    modport source (output valid, func, pixel, coef_index, coef_value, input ready);
    modport sink (input valid, func, pixel, coef_index, coef_value, output ready);
endinterface

interface wcf_out_if #(parameter int X_W = 10);
    import wcf_pkg::*;
    logic             valid;
    logic             ready;
    logic [X_W-1:0]   out_x;
    logic [ROW_W-1:0] out_y;
    logic [PIX_W-1:0] value;
    logic             frame_last;

    modport source (output valid, out_x, out_y, value, frame_last, input ready);
    modport sink (input valid, out_x, out_y, value, frame_last, output ready);
endinterface

### design/window_convolution_filter_top.sv
// window convolution filter top: configuration registers and pipeline enable
// depends on wcf_pkg, wcf_ifs, wcf_window, wcf_mac
// result path: stage 1, window, product, row sum, total and output registers
// throughput: one item per cycle, set by the single line ram read-modify-write per pixel,
// but the whole pipeline holds while a finished result waits at the output register
// reset: after rst_n rises, the line ram is cleared; no item is taken meanwhile
// reset clears window and coefficients and sets radius 1, width 640, height 480
module window_convolution_filter_top #(
    parameter int MAX_RADIUS     = 2,
    parameter int MAX_WIDTH      = 1024,
    parameter int COEF_FRAC_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wcf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wcf_pkg::CFG_DATA_W-1:0]   cfg_data,
    wcf_in_if.sink                           pix,
    wcf_out_if.source                        res
);
    import wcf_pkg::*;

    localparam int KSIDE = 2 * MAX_RADIUS + 1;
    localparam int NTAP  = KSIDE * KSIDE;
    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [RAD_W-1:0]   radius_reg;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic               en;

    logic [NTAP-1:0][PIX_W-1:0]  win;
    logic [NTAP-1:0][COEF_W-1:0] coefs;
    wcf_meta_t                   meta;
    logic [COL_W-1:0]            meta_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RAD_W'(1);
            width_reg  <= IMG_W_W'(640);
            height_reg <= IMG_H_W'(480);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                CFG_WIDTH:  width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_HEIGHT: height_reg <= cfg_data[IMG_H_W-1:0];
                default:    ;
            endcase
        end
    end

    // the pipeline advances unless a result waits
    assign en = !res.valid || res.ready;

    wcf_window #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .radius       (radius_reg),
        .image_width  (width_reg),
        .image_height (height_reg),
        .pix          (pix),
        .win          (win),
        .coefs        (coefs),
        .meta         (meta),
        .meta_x       (meta_x)
    );

    wcf_mac #(
        .MAX_RADIUS     (MAX_RADIUS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .COL_W          (COL_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .win    (win),
        .coefs  (coefs),
        .meta   (meta),
        .meta_x (meta_x),
        .res    (res)
    );
endmodule

### design/wcf_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module wcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### design/wcf_window.sv
// raster counters, line store read-modify-write, window and coefficient registers
// depends on wcf_pkg, wcf_ifs and wcf_ram
module wcf_window #(
    parameter int MAX_RADIUS = 2,
    parameter int MAX_WIDTH  = 1024,
    parameter int KSIDE      = 2 * MAX_RADIUS + 1,
    parameter int NTAP       = KSIDE * KSIDE,
    parameter int COL_W      = $clog2(MAX_WIDTH)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic [wcf_pkg::RAD_W-1:0]              radius,
    input  logic [wcf_pkg::IMG_W_W-1:0]            image_width,
    input  logic [wcf_pkg::IMG_H_W-1:0]            image_height,
    wcf_in_if.sink                                 pix,
    output logic [NTAP-1:0][wcf_pkg::PIX_W-1:0]    win,
    output logic [NTAP-1:0][wcf_pkg::COEF_W-1:0]   coefs,
    output wcf_pkg::wcf_meta_t                     meta,
    output logic [COL_W-1:0]                       meta_x
);
    import wcf_pkg::*;

    localparam int NLINES = 2 * MAX_RADIUS;
    localparam int LINE_W = PIX_W * NLINES;
    localparam int CLR_W  = COL_W + 1;

    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             clr_busy;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             accept, acc_pix;

    logic [DIM_W-1:0] w_eff, c, c_inc, r_dbl;
    logic [ROW_W-1:0] h_eff, row;
    logic [RAD_W-1:0] r_eff;

    logic              s1_valid_reg, s1_func_reg, s1_emit_reg, s1_last_reg, s1_fwd_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [COL_W-1:0]  s1_addr_reg, s1_x_reg;
    logic [ROW_W-1:0]  s1_y_reg;
    logic [RAD_W-1:0]  s1_r_reg, meta_r_reg;
    logic [CIDX_W-1:0] s1_cidx_reg;
    logic [COEF_W-1:0] s1_cval_reg;
    logic [LINE_W-1:0] fwd_data_reg;
    wcf_meta_t         meta_reg;
    logic [COL_W-1:0]  meta_x_reg;

    logic [LINE_W-1:0] ram_rdata, line_rd, line_wr, ram_wdata;
    logic [COL_W-1:0]  ram_waddr;
    logic              ram_we, s1_pix_go;
    logic [PIX_W-1:0]  column [KSIDE];
    logic [PIX_W-1:0]  win_reg [KSIDE][KSIDE];
    logic [COEF_W-1:0] coef_reg [NTAP];

    assign clr_busy  = (clr_cnt_reg != CLR_W'(MAX_WIDTH));
    assign pix.ready = en && !clr_busy;
    assign accept    = pix.valid && pix.ready;
    assign acc_pix   = accept && (pix.func == FUNC_PIXEL);

    // effective geometry
    always_comb
    begin
        if (image_width == '0)
            w_eff = DIM_W'(1);
        else if (DIM_W'(image_width) > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(image_width);
        h_eff = (image_height == '0) ? ROW_W'(1) : image_height;
        if (radius == '0)
            r_eff = RAD_W'(1);
        else if (DIM_W'(radius) > DIM_W'(MAX_RADIUS))
            r_eff = RAD_W'(MAX_RADIUS);
        else
            r_eff = radius;
        c     = (DIM_W'(col_reg) >= w_eff) ? '0 : DIM_W'(col_reg);
        row   = (row_reg >= h_eff) ? '0 : row_reg;
        c_inc = c + DIM_W'(1);
        r_dbl = DIM_W'({r_eff, 1'b0});
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc_pix)
        begin
            if (c_inc >= w_eff)
            begin
                col_next = '0;
                row_next = (row + ROW_W'(1) >= h_eff) ? '0 : row + ROW_W'(1);
            end
            else
            begin
                col_next = c_inc[COL_W-1:0];
                row_next = row;
            end
        end
    end

    assign clr_cnt_next = clr_busy ? clr_cnt_reg + CLR_W'(1) : clr_cnt_reg;

    // column assembly and line shift, forwarded when the same column was just written
    assign line_rd   = s1_fwd_reg ? fwd_data_reg : ram_rdata;
    assign s1_pix_go = en && s1_valid_reg && (s1_func_reg == FUNC_PIXEL);

    always_comb
    begin
        for (int k = 0; k < NLINES; k++)
        begin
            column[k] = line_rd[k*PIX_W +: PIX_W];
        end
        column[NLINES] = s1_pix_reg;
        for (int k = 0; k < NLINES; k++)
        begin
            line_wr[k*PIX_W +: PIX_W] = column[k+1];
        end
    end

    assign ram_we    = clr_busy || s1_pix_go;
    assign ram_waddr = clr_busy ? clr_cnt_reg[COL_W-1:0] : s1_addr_reg;
    assign ram_wdata = clr_busy ? '0 : line_wr;

    wcf_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (acc_pix),
        .raddr (c[COL_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
            meta_reg     <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            if (en)
            begin
                s1_valid_reg <= accept;
                s1_fwd_reg   <= acc_pix && s1_pix_go && (s1_addr_reg == c[COL_W-1:0]);
                meta_reg.emit <= s1_pix_go && s1_emit_reg;
                meta_reg.last <= s1_last_reg;
                meta_reg.y    <= s1_y_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= pix.func;
            s1_pix_reg  <= pix.pixel;
            s1_addr_reg <= c[COL_W-1:0];
            s1_emit_reg <= (c >= r_dbl) && (DIM_W'(row) >= r_dbl);
            s1_x_reg    <= COL_W'(c - DIM_W'(r_eff));
            s1_y_reg    <= row - ROW_W'(r_eff);
            s1_last_reg <= (c == w_eff - DIM_W'(1)) && (row == h_eff - ROW_W'(1));
            s1_r_reg    <= r_eff;
            s1_cidx_reg <= pix.coef_index;
            s1_cval_reg <= pix.coef_value;
        end
        if (en)
        begin
            fwd_data_reg <= line_wr;
            meta_x_reg   <= s1_x_reg;
            meta_r_reg   <= s1_r_reg;
        end
    end

    // window shift and coefficient table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KSIDE; i++)
            begin
                for (int j = 0; j < KSIDE; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
            for (int t = 0; t < NTAP; t++)
            begin
                coef_reg[t] <= '0;
            end
        end
        else
        begin
            if (s1_pix_go)
            begin
                for (int i = 0; i < KSIDE; i++)
                begin
                    for (int j = 0; j + 1 < KSIDE; j++)
                    begin
                        win_reg[i][j] <= win_reg[i][j+1];
                    end
                    win_reg[i][KSIDE-1] <= column[i];
                end
            end
            if (en && s1_valid_reg && (s1_func_reg == FUNC_COEF))
            begin
                for (int t = 0; t < NTAP; t++)
                begin
                    if (t < 32 && s1_cidx_reg == CIDX_W'(t))
                    begin
                        coef_reg[t] <= s1_cval_reg;
                    end
                end
            end
        end
    end

    // map kernel positions onto the newest rows and columns of the full window
    always_comb
    begin
        for (int i = 0; i < KSIDE; i++)
        begin
            for (int j = 0; j < KSIDE; j++)
            begin
                win[i*KSIDE+j]   = win_reg[i][j];
                coefs[i*KSIDE+j] = '0;
                for (int rr = 1; rr <= MAX_RADIUS; rr++)
                begin
                    if (rr < 4 && meta_r_reg == RAD_W'(rr)
                        && i >= 2 * (MAX_RADIUS - rr) && j >= 2 * (MAX_RADIUS - rr))
                    begin
                        coefs[i*KSIDE+j] = coef_reg[(i - 2 * (MAX_RADIUS - rr)) * (2*rr + 1)
                                                    + (j - 2 * (MAX_RADIUS - rr))];
                    end
                end
            end
        end
    end

    assign meta   = meta_reg;
    assign meta_x = meta_x_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !accept) else $error("item transfer during line store clear");
    a_fwd_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fwd_reg |-> s1_valid_reg) else $error("forward flag without item");
    a_emit_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_pix_go && s1_emit_reg) |=> meta_reg.emit) else $error("interior pixel dropped");
endmodule

### design/wcf_mac.sv
// tap multipliers, registered adder tree, rounding, saturation and output register
// depends on wcf_pkg and wcf_ifs
module wcf_mac #(
    parameter int MAX_RADIUS     = 2,
    parameter int COEF_FRAC_BITS = 12,
    parameter int COL_W          = 10,
    parameter int KSIDE          = 2 * MAX_RADIUS + 1,
    parameter int NTAP           = KSIDE * KSIDE
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic [NTAP-1:0][wcf_pkg::PIX_W-1:0]  win,
    input  logic [NTAP-1:0][wcf_pkg::COEF_W-1:0] coefs,
    input  wcf_pkg::wcf_meta_t                   meta,
    input  logic [COL_W-1:0]                     meta_x,
    wcf_out_if.source                            res
);
    import wcf_pkg::*;

    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int SROW_W = PROD_W + $clog2(KSIDE);
    localparam int TOT_W  = SROW_W + $clog2(KSIDE);
    localparam int MAG_W  = TOT_W + 1;

    logic signed [PROD_W-1:0] prod_reg [NTAP];
    logic signed [SROW_W-1:0] srow_reg [KSIDE];
    logic signed [SROW_W-1:0] srow_next [KSIDE];
    logic signed [TOT_W-1:0]  tot_reg, tot_next;
    logic [MAG_W-1:0]         mag;
    logic [PIX_W-1:0]         value_next;

    wcf_meta_t        p_meta_reg, s_meta_reg, t_meta_reg, o_meta_reg;
    logic [COL_W-1:0] p_x_reg, s_x_reg, t_x_reg, o_x_reg;
    logic [PIX_W-1:0] o_value_reg;

    always_comb
    begin
        for (int i = 0; i < KSIDE; i++)
        begin
            srow_next[i] = '0;
            for (int j = 0; j < KSIDE; j++)
            begin
                srow_next[i] = srow_next[i] + SROW_W'(prod_reg[i*KSIDE+j]);
            end
        end
        tot_next = '0;
        for (int i = 0; i < KSIDE; i++)
        begin
            tot_next = tot_next + TOT_W'(srow_reg[i]);
        end
    end

    // round half up on the non-negative side, negative sums clamp to zero
    always_comb
    begin
        mag = (MAG_W'(unsigned'(tot_reg)) + (MAG_W'(1) << (COEF_FRAC_BITS - 1)))
              >> COEF_FRAC_BITS;
        if (tot_reg < 0)
            value_next = '0;
        else if (mag > MAG_W'(255))
            value_next = '1;
        else
            value_next = mag[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int t = 0; t < NTAP; t++)
            begin
                prod_reg[t] <= PROD_W'($signed(coefs[t]) * $signed({1'b0, win[t]}));
            end
            for (int i = 0; i < KSIDE; i++)
            begin
                srow_reg[i] <= srow_next[i];
            end
            tot_reg     <= tot_next;
            o_value_reg <= value_next;
            p_x_reg     <= meta_x;
            s_x_reg     <= p_x_reg;
            t_x_reg     <= s_x_reg;
            o_x_reg     <= t_x_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_meta_reg <= '0;
            s_meta_reg <= '0;
            t_meta_reg <= '0;
            o_meta_reg <= '0;
        end
        else if (en)
        begin
            p_meta_reg <= meta;
            s_meta_reg <= p_meta_reg;
            t_meta_reg <= s_meta_reg;
            o_meta_reg <= t_meta_reg;
        end
    end

    assign res.valid      = o_meta_reg.emit;
    assign res.out_x      = o_x_reg;
    assign res.out_y      = o_meta_reg.y;
    assign res.value      = o_value_reg;
    assign res.frame_last = o_meta_reg.last;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.ready) |=> (res.valid && $stable(o_value_reg)))
        else $error("result changed while stalled");
    a_pipe_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (en && t_meta_reg.emit) |=> res.valid) else $error("result lost in tree");
    a_bubble_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (!en) |=> $stable(t_meta_reg)) else $error("pipeline moved while stalled");
endmodule

### dv/wcf_tb_ifs_note.sv
// testbench support: shared helper types for the filter test
// depends on wcf_pkg; the stream interfaces come from the design's wcf_ifs
`timescale 1ns / 1ps
package wcf_tb_pkg;
    import wcf_pkg::*;

    typedef struct packed {
        logic [9:0]       x;
        logic [ROW_W-1:0] y;
        logic [PIX_W-1:0] value;
        logic             last;
    } filt_result_t;
endpackage

### dv/window_convolution_filter_top_test.sv
// self-checking test of window_convolution_filter_top: a behavioral filter model
// predicts each filtered pixel and a checker compares every output transfer in order
// depends on wcf_pkg, wcf_ifs, wcf_tb_pkg and the filter rtl
`timescale 1ns / 1ps
module window_convolution_filter_top_test;
    import wcf_pkg::*;
    import wcf_tb_pkg::*;

    localparam int LIMIT = 2000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wcf_in_if pix ();
    wcf_out_if #(.X_W(10)) res ();

    window_convolution_filter_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pix(pix.sink), .res(res.source)
    );

    // model state
    logic signed [COEF_W-1:0] m_coef [25];
    logic [7:0] m_lines [4][1024];
    logic [7:0] m_win [5][5];
    int unsigned m_col, m_row;
    int unsigned mdl_rad, m_width, m_height;

    filt_result_t expected_q[$];
    int errors = 0;
    int n_results = 0;
    int n_items = 0;
    int src_idle = 0;
    int snk_idle = 0;
    bit hold_off = 0;
    longint cycles = 0;

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout at %0t", $time);
            $display("window_convolution_filter_top_test: FAIL");
            $finish;
        end
    end

    function automatic int unsigned round_clip(longint acc);
        longint m;
        if (acc < 0)
            return 0;
        m = (acc + 2048) >>> 12;
        return (m > 255) ? 255 : int'(m);
    endfunction

    // advance the model by one input item
    task automatic predict_item(logic f, logic [7:0] p, logic [4:0] ci,
                                logic signed [COEF_W-1:0] cv);
        int unsigned r, side, w, h, c, row, off;
        logic [7:0] column [5];
        longint acc;
        filt_result_t e;
        if (f == FUNC_COEF)
        begin
            if (ci < 25)
                m_coef[ci] = cv;
            return;
        end
        r = (mdl_rad < 1) ? 1 : (mdl_rad > 2 ? 2 : mdl_rad);
        side = 2 * r + 1;
        w = (m_width < 1) ? 1 : (m_width > 1024 ? 1024 : m_width);
        h = (m_height < 1) ? 1 : m_height;
        if (m_col >= w) m_col = 0;
        if (m_row >= h) m_row = 0;
        c = m_col;
        row = m_row;
        for (int k = 0; k < 4; k++)
            column[k] = m_lines[k][c];
        column[4] = p;
        for (int k = 0; k < 4; k++)
            m_lines[k][c] = column[k + 1];
        for (int dy = 0; dy < 5; dy++)
        begin
            for (int dx = 0; dx < 4; dx++)
                m_win[dy][dx] = m_win[dy][dx + 1];
            m_win[dy][4] = column[dy];
        end
        if (c >= 2 * r && row >= 2 * r)
        begin
            off = 5 - side;
            acc = 0;
            for (int dy = 0; dy < side; dy++)
                for (int dx = 0; dx < side; dx++)
                    acc += longint'(m_coef[dy * side + dx]) *
                           longint'({1'b0, m_win[off + dy][off + dx]});
            e.x = 10'(c - r);
            e.y = 12'(row - r);
            e.value = 8'(round_clip(acc));
            e.last = (c == w - 1 && row == h - 1);
            expected_q.push_back(e);
        end
        m_col = c + 1;
        if (m_col >= w)
        begin
            m_col = 0;
            m_row = row + 1;
            if (m_row >= h) m_row = 0;
        end
    endtask

    // valid stays high after a transfer; the next item's idle wait or drain() takes it down
    task automatic send_item(logic f, logic [7:0] p, logic [4:0] ci,
                             logic signed [COEF_W-1:0] cv);
        while ($urandom_range(99) < src_idle)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid <= 1'b1;
        pix.func <= f;
        pix.pixel <= p;
        pix.coef_index <= ci;
        pix.coef_value <= cv;
        // ready is settled at the falling edge before the edge that takes the transfer
        @(negedge clk);
        while (!pix.ready)
            @(negedge clk);
        @(posedge clk);
        predict_item(f, p, ci, cv);
        n_items++;
    endtask

    task automatic send_pixel(logic [7:0] p);
        send_item(FUNC_PIXEL, p, 5'd0, '0);
    endtask

    task automatic send_coef(int idx, int v);
        send_item(FUNC_COEF, $urandom, 5'(idx), COEF_W'(v));
    endtask

    // receiver ready and result checker
    always @(posedge clk)
    begin
        filt_result_t e;
        if (rst_n && res.valid && res.ready)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result x=%0d y=%0d v=%0d", $time,
                         res.out_x, res.out_y, res.value);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res.out_x !== e.x || res.out_y !== e.y || res.value !== e.value ||
                    res.frame_last !== e.last)
                begin
                    $display("%0t mismatch exp x=%0d y=%0d v=%0d l=%0d act x=%0d y=%0d v=%0d l=%0d",
                             $time, e.x, e.y, e.value, e.last, res.out_x, res.out_y,
                             res.value, res.frame_last);
                    errors++;
                end
            end
        end
        res.ready <= !hold_off && ($urandom_range(99) >= snk_idle);
    end

    task automatic drain();
        int guard;
        guard = 0;
        pix.valid <= 1'b0;
        while (expected_q.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int v);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(v);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_RADIUS: mdl_rad = v & 3;
            CFG_WIDTH:  m_width = v & 'h7ff;
            CFG_HEIGHT: m_height = v & 'hfff;
            default: ;
        endcase
    endtask

    task automatic set_shape(int r, int w, int h);
        write_reg(CFG_RADIUS, r);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
    endtask

    task automatic load_kernel(int n);
        for (int i = 0; i < n; i++)
            send_coef(i, int'($urandom_range(0, 'h3ffff)) - (1 << 17));
    endtask

    // directed: coefficient extremes, identity kernel, pixel extremes
    task automatic test_directed();
        set_shape(1, 5, 5);
        for (int i = 0; i < 9; i++)
            send_coef(i, (i == 4) ? 4096 : 0);
        send_coef(31, 131071);
        for (int i = 0; i < 10; i++)
            send_pixel((i % 2) ? 8'hff : 8'h00);
        send_coef(0, -131072);
        send_coef(8, 131071);
        for (int i = 0; i < 15; i++)
            send_pixel(8'(i * 37));
    endtask

    task automatic test_random_frames(int n);
        int r, w, h, pixels;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 3);
            w = ($urandom_range(9) == 0) ? $urandom_range(0, 2047) : $urandom_range(5, 12);
            if (w > 40) w = ($urandom_range(1)) ? 1024 : 2047;
            h = $urandom_range(0, 8);
            if (i == 0)
            begin
                r = 2;
                w = 1024;
                h = 5;
            end
            set_shape(r, w, h);
            load_kernel(($urandom_range(3) == 0) ? 25 : 9);
            if ($urandom_range(3) == 0)
                send_coef($urandom_range(25, 31), 0);
            pixels = (w > 40) ? 40 : $urandom_range(20, 80);
            for (int k = 0; k < pixels; k++)
                send_pixel($urandom);
        end
    endtask

    task automatic test_backpressure();
        set_shape(1, 6, 6);
        load_kernel(9);
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            for (int k = 0; k < 60; k++)
                send_pixel($urandom);
        join
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = CFG_RADIUS;
        cfg_data = '0;
        pix.valid = 0;
        pix.func = FUNC_PIXEL;
        pix.pixel = '0;
        pix.coef_index = '0;
        pix.coef_value = '0;
        res.ready = 0;
        for (int i = 0; i < 25; i++) m_coef[i] = '0;
        for (int k = 0; k < 4; k++)
            for (int c = 0; c < 1024; c++) m_lines[k][c] = '0;
        for (int a = 0; a < 5; a++)
            for (int b = 0; b < 5; b++) m_win[a][b] = '0;
        m_col = 0;
        m_row = 0;
        mdl_rad = 1;
        m_width = 640;
        m_height = 480;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        src_idle = 16;
        snk_idle = 49;
        test_random_frames(6);
        src_idle = 49;
        snk_idle = 16;
        test_random_frames(6);
        test_backpressure();
        src_idle = 0;
        snk_idle = 0;
        test_random_frames(4);
        drain();
        $display("covered %0d input items and %0d filtered results over radius, size and stall mixes",
                 n_items, n_results);
        if (errors == 0 && expected_q.size() == 0)
            $display("window_convolution_filter_top_test: PASS");
        else
            $display("window_convolution_filter_top_test: FAIL");
        $finish;
    end
endmodule

### sim.f
design/wcf_pkg.sv
design/wcf_ifs.sv
design/wcf_ram.sv
design/wcf_window.sv
design/wcf_mac.sv
design/window_convolution_filter_top.sv
dv/wcf_tb_ifs_note.sv
dv/window_convolution_filter_top_test.sv
